// File: design/bcfu_pkg.sv
// Shared types and codes for the branch control-flow unit.
package bcfu_pkg;

    // Instruction classes
    localparam logic [3:0] MODE_JRCC  = 4'd0;
    localparam logic [3:0] MODE_BTJT  = 4'd1;
    localparam logic [3:0] MODE_BTJF  = 4'd2;
    localparam logic [3:0] MODE_JP    = 4'd3;
    localparam logic [3:0] MODE_JPF   = 4'd4;
    localparam logic [3:0] MODE_CALL  = 4'd5;
    localparam logic [3:0] MODE_CALLR = 4'd6;
    localparam logic [3:0] MODE_CALLF = 4'd7;
    localparam logic [3:0] MODE_INT   = 4'd8;
    localparam logic [3:0] MODE_RET   = 4'd9;
    localparam logic [3:0] MODE_RETF  = 4'd10;

    // Relative-jump conditions (flag tests, then signed compares, then unsigned compares)
    localparam logic [4:0] COND_T  = 5'd0;
    localparam logic [4:0] COND_F  = 5'd1;
    localparam logic [4:0] COND_EQ = 5'd2;
    localparam logic [4:0] COND_NE = 5'd3;
    localparam logic [4:0] COND_H  = 5'd4;
    localparam logic [4:0] COND_NH = 5'd5;
    localparam logic [4:0] COND_MI = 5'd6;
    localparam logic [4:0] COND_PL = 5'd7;
    localparam logic [4:0] COND_V  = 5'd8;
    localparam logic [4:0] COND_NV = 5'd9;
    localparam logic [4:0] COND_GE = 5'd10;
    localparam logic [4:0] COND_GT = 5'd11;
    localparam logic [4:0] COND_LE = 5'd12;
    localparam logic [4:0] COND_LT = 5'd13;
    localparam logic [4:0] COND_HS = 5'd14;
    localparam logic [4:0] COND_HI = 5'd15;
    localparam logic [4:0] COND_LS = 5'd16;
    localparam logic [4:0] COND_LO = 5'd17;

    // Condition code bit positions
    localparam int FL_V = 7;
    localparam int FL_H = 4;
    localparam int FL_N = 2;
    localparam int FL_Z = 1;
    localparam int FL_C = 0;

    typedef struct packed {
        logic [3:0]        mode;
        logic [4:0]        cond;
        logic [2:0]        bit_index;
        logic [7:0]        test_byte;
        logic signed [7:0] offset;
        logic [23:0]       target;
        logic              indirect;
        logic              index_y;
        logic [23:0]       return_address;
        logic [23:0]       pc_in;
        logic [15:0]       sp_in;
        logic [7:0]        flags_in;
    } t_bcfu_in;

    typedef struct packed {
        logic [23:0] pc_out;
        logic [15:0] sp_out;
        logic [7:0]  flags_out;
        logic        taken;
        logic [3:0]  cycles;
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_byte;
        logic        last;
    } t_bcfu_out;

    // First output word of an instruction plus what the push sequencer needs
    typedef struct packed {
        t_bcfu_out   first;
        logic [1:0]  last_beat;   // index of the final word (0, 1 or 2)
        logic [23:0] push_pc;     // return address bytes to push
    } t_bcfu_res;

endpackage

// File: design/branch_control_flow_unit.sv
// Top level of the branch control-flow execute unit.
//
// One instruction word enters on the input channel (i_in_valid / o_in_ready,
// payload i_in_word) with its operands resolved and the current pc, sp and
// condition codes. Result words leave on the output channel (o_out_valid /
// i_out_ready, payload o_out_word).
// The first result word is registered: the input register loads at the
// accepting edge, and the result register takes the result once it is free.
// Throughput: one instruction per cycle while the receiver is ready, except calls; call and
// callr occupy the result register for 2 words, callf for 3, one pushed
// stack byte per word, low byte first, so the next instruction waits there.
// The input register can take one word while a finished result waits,
// so one item is buffered when the receiver stalls; results are held
// unchanged until taken.
// Reset is synchronous, active low, and empties both registers; no stored
// state survives an instruction.
module branch_control_flow_unit
    import bcfu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_bcfu_in  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_bcfu_out o_out_word
);

    logic      r_s1_valid;
    t_bcfu_in  r_s1_item;
    t_bcfu_res s1_res;
    logic      s1_take;
    logic      in_fire;

    assign o_in_ready = !r_s1_valid || s1_take;
    assign in_fire    = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in_word;
        end
    end

    bcfu_resolve u_resolve (
        .i_item (r_s1_item),
        .o_res  (s1_res)
    );

    bcfu_beat u_beat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (r_s1_valid),
        .i_res       (s1_res),
        .o_res_take  (s1_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// File: design/bcfu_resolve.sv
// Combinational branch resolution: next pc, sp, flags, cycles and first word.
module bcfu_resolve
    import bcfu_pkg::*;
(
    input  t_bcfu_in  i_item,
    output t_bcfu_res o_res
);

    logic [23:0] near_pc;
    logic [23:0] rel_pc;
    logic        cc_hit;
    logic        bit_hit;
    logic        lt;
    logic [7:0]  fl;

    assign fl      = i_item.flags_in;
    assign lt      = fl[FL_N] ^ fl[FL_V];
    assign near_pc = {i_item.pc_in[23:16], i_item.target[15:0]};
    assign rel_pc  = i_item.pc_in + {{16{i_item.offset[7]}}, i_item.offset};
    assign bit_hit = i_item.test_byte[i_item.bit_index] ^ (i_item.mode == MODE_BTJF);

    // Condition evaluation for jrcc; unknown codes never branch
    always_comb begin
        case (i_item.cond)
            COND_T:  cc_hit = 1'b1;
            COND_F:  cc_hit = 1'b0;
            COND_EQ: cc_hit = fl[FL_Z];
            COND_NE: cc_hit = !fl[FL_Z];
            COND_H:  cc_hit = fl[FL_H];
            COND_NH: cc_hit = !fl[FL_H];
            COND_MI: cc_hit = fl[FL_N];
            COND_PL: cc_hit = !fl[FL_N];
            COND_V:  cc_hit = fl[FL_V];
            COND_NV: cc_hit = !fl[FL_V];
            COND_GE: cc_hit = !lt;
            COND_GT: cc_hit = !(fl[FL_Z] || lt);
            COND_LE: cc_hit = fl[FL_Z] || lt;
            COND_LT: cc_hit = lt;
            COND_HS: cc_hit = !fl[FL_C];
            COND_HI: cc_hit = !fl[FL_C] && !fl[FL_Z];
            COND_LS: cc_hit = fl[FL_C] || fl[FL_Z];
            COND_LO: cc_hit = fl[FL_C];
            default: cc_hit = 1'b0;
        endcase
    end

    // Per-mode result; calls start with the low pc byte pushed at sp
    always_comb begin
        o_res.first               = '0;
        o_res.first.pc_out        = i_item.pc_in;
        o_res.first.sp_out        = i_item.sp_in;
        o_res.first.flags_out     = fl;
        o_res.first.last          = 1'b1;
        o_res.last_beat           = 2'd0;
        o_res.push_pc             = i_item.pc_in;
        case (i_item.mode)
            MODE_JRCC: begin
                o_res.first.taken  = cc_hit;
                o_res.first.pc_out = cc_hit ? rel_pc : i_item.pc_in;
                o_res.first.cycles = cc_hit ? 4'd2 : 4'd1;
            end
            MODE_BTJT, MODE_BTJF: begin
                o_res.first.taken         = bit_hit;
                o_res.first.pc_out        = bit_hit ? rel_pc : i_item.pc_in;
                o_res.first.cycles        = bit_hit ? 4'd3 : 4'd2;
                o_res.first.flags_out[FL_C] = bit_hit;
            end
            MODE_JP: begin
                o_res.first.taken  = 1'b1;
                o_res.first.pc_out = near_pc;
                o_res.first.cycles = i_item.indirect ? 4'd5 :
                                     (i_item.index_y ? 4'd2 : 4'd1);
            end
            MODE_JPF: begin
                o_res.first.taken  = 1'b1;
                o_res.first.pc_out = i_item.target;
                o_res.first.cycles = i_item.indirect ? 4'd6 : 4'd2;
            end
            MODE_INT: begin
                o_res.first.taken  = 1'b1;
                o_res.first.pc_out = i_item.target;
                o_res.first.cycles = 4'd2;
            end
            MODE_RET: begin
                o_res.first.taken  = 1'b1;
                o_res.first.pc_out = {i_item.pc_in[23:16], i_item.return_address[15:0]};
                o_res.first.sp_out = i_item.sp_in + 16'd2;
                o_res.first.cycles = 4'd4;
            end
            MODE_RETF: begin
                o_res.first.taken  = 1'b1;
                o_res.first.pc_out = i_item.return_address;
                o_res.first.sp_out = i_item.sp_in + 16'd3;
                o_res.first.cycles = 4'd5;
            end
            MODE_CALL, MODE_CALLR, MODE_CALLF: begin
                o_res.first.taken         = 1'b1;
                o_res.first.write_valid   = 1'b1;
                o_res.first.write_address = i_item.sp_in;
                o_res.first.write_byte    = i_item.pc_in[7:0];
                o_res.first.sp_out        = i_item.sp_in - 16'd1;
                o_res.first.last          = 1'b0;
                if (i_item.mode == MODE_CALL) begin
                    o_res.first.pc_out = near_pc;
                    o_res.first.cycles = i_item.indirect ? 4'd6 : 4'd4;
                    o_res.last_beat    = 2'd1;
                end else if (i_item.mode == MODE_CALLR) begin
                    o_res.first.pc_out = rel_pc;
                    o_res.first.cycles = 4'd4;
                    o_res.last_beat    = 2'd1;
                end else begin
                    o_res.first.pc_out = i_item.target;
                    o_res.first.cycles = i_item.indirect ? 4'd8 : 4'd5;
                    o_res.last_beat    = 2'd2;
                end
            end
            default: begin
                // unknown mode: pass state through, nothing happens
                o_res.first.cycles = 4'd0;
            end
        endcase
    end

endmodule

// File: design/bcfu_beat.sv
// Result register and stack-push sequencer: emits one word per pushed byte for calls, a single word otherwise.
module bcfu_beat
    import bcfu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_bcfu_res i_res,
    output logic      o_res_take,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_bcfu_out o_out_word
);

    logic        r_valid;
    t_bcfu_out   r_word;
    logic [23:0] r_push_pc;
    logic [1:0]  r_beat;
    logic [1:0]  r_last_beat;

    logic        out_fire;
    logic        load_ok;
    logic [1:0]  next_beat;
    t_bcfu_out   n_word;

    assign out_fire   = r_valid && i_out_ready;
    assign load_ok    = !r_valid || (out_fire && r_word.last);
    assign o_res_take = i_res_valid && load_ok;
    assign next_beat  = r_beat + 2'd1;

    // Next push word: address follows the decremented sp
    always_comb begin
        n_word               = r_word;
        n_word.write_address = r_word.sp_out;
        n_word.sp_out        = r_word.sp_out - 16'd1;
        n_word.write_byte    = (next_beat == 2'd1) ? r_push_pc[15:8] : r_push_pc[23:16];
        n_word.last          = (next_beat == r_last_beat);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else if (o_res_take) begin
            r_valid <= 1'b1;
            r_beat  <= 2'd0;
        end else if (out_fire) begin
            r_valid <= !r_word.last;
            r_beat  <= next_beat;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_res_take) begin
            r_word      <= i_res.first;
            r_push_pc   <= i_res.push_pc;
            r_last_beat <= i_res.last_beat;
        end else if (out_fire && !r_word.last) begin
            r_word <= n_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

// File: design/bcfu_checker.sv
// Port-level checks for the branch control-flow unit, bound to the top level.
module bcfu_checker
    import bcfu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_bcfu_out o_out_word
);

    // Stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // Push words of one call follow back to back
    a_push_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_word.last |=> o_out_valid)
        else $error("gap inside a call push sequence");

    // Each further push goes one byte lower, same target pc
    a_push_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_word.last |=>
        o_out_word.write_address == $past(o_out_word.write_address) - 16'd1 &&
        o_out_word.pc_out == $past(o_out_word.pc_out))
        else $error("push address or pc wrong");

    // Non-final words are always stack writes
    a_nonlast_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |-> o_out_word.write_valid)
        else $error("non-final word without a stack write");

    // No write means zero address and byte
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.write_valid |->
        o_out_word.write_address == 16'd0 && o_out_word.write_byte == 8'd0)
        else $error("write fields set without a write");

endmodule

bind branch_control_flow_unit bcfu_checker u_bcfu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// File: verif/branch_control_flow_unit_test.sv
// Self-checking testbench for the branch control-flow unit: directed and random instructions.
module branch_control_flow_unit_test;
    import bcfu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes outside the defined ranges: treated as no-op mode / never-true condition
    localparam logic [3:0] MODE_UNKNOWN_FIRST = 4'd11;
    localparam logic [3:0] MODE_UNKNOWN_LAST  = 4'd15;
    localparam logic [4:0] COND_UNKNOWN_FIRST = 5'd18;
    localparam logic [4:0] COND_UNKNOWN_LAST  = 5'd31;

    localparam int STALL_LIMIT  = 1000;  // cycles with no word moved on either side
    localparam int DRAIN_CYCLES = 10;    // settle margin after the last result

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_bcfu_in  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_bcfu_out o_out_word;

    t_bcfu_in  pending_instrs[$];
    t_bcfu_out predicted_words[$];
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;

    branch_control_flow_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Condition evaluation against the CC byte
    function automatic bit cond_met(logic [4:0] cond, logic [7:0] cc);
        bit lt;
        lt = cc[FL_N] ^ cc[FL_V];
        case (cond)
            COND_T:  return 1'b1;
            COND_EQ: return cc[FL_Z];
            COND_NE: return !cc[FL_Z];
            COND_H:  return cc[FL_H];
            COND_NH: return !cc[FL_H];
            COND_MI: return cc[FL_N];
            COND_PL: return !cc[FL_N];
            COND_V:  return cc[FL_V];
            COND_NV: return !cc[FL_V];
            COND_GE: return !lt;
            COND_GT: return !(cc[FL_Z] || lt);
            COND_LE: return cc[FL_Z] || lt;
            COND_LT: return lt;
            COND_HS: return !cc[FL_C];
            COND_HI: return !cc[FL_C] && !cc[FL_Z];
            COND_LS: return cc[FL_C] || cc[FL_Z];
            COND_LO: return cc[FL_C];
            default: return 1'b0;   // F and undefined codes
        endcase
    endfunction

    // pc plus sign-extended displacement, wrapping at 24 bits
    function automatic logic [23:0] rel_pc(logic [23:0] pc, logic signed [7:0] disp);
        return pc + {{16{disp[7]}}, disp};
    endfunction

    // Work out the result words of one instruction and queue them
    task automatic predict_branch(input t_bcfu_in w);
        t_bcfu_out r;
        logic [23:0] near_pc;
        logic [15:0] sp;
        int          n_push;
        bit          hit;
        near_pc = {w.pc_in[23:16], w.target[15:0]};
        n_push  = 0;
        r = '0;
        r.pc_out    = w.pc_in;
        r.sp_out    = w.sp_in;
        r.flags_out = w.flags_in;
        r.last      = 1'b1;
        case (w.mode)
            MODE_JRCC: begin
                hit = cond_met(w.cond, w.flags_in);
                r.taken  = hit;
                r.cycles = hit ? 4'd2 : 4'd1;
                if (hit) r.pc_out = rel_pc(w.pc_in, w.offset);
            end
            MODE_BTJT, MODE_BTJF: begin
                hit = w.test_byte[w.bit_index] ^ (w.mode == MODE_BTJF);
                r.taken  = hit;
                r.cycles = hit ? 4'd3 : 4'd2;
                r.flags_out[FL_C] = hit;
                if (hit) r.pc_out = rel_pc(w.pc_in, w.offset);
            end
            MODE_JP: begin
                r.pc_out = near_pc;
                r.taken  = 1'b1;
                r.cycles = w.indirect ? 4'd5 : (w.index_y ? 4'd2 : 4'd1);
            end
            MODE_JPF: begin
                r.pc_out = w.target;
                r.taken  = 1'b1;
                r.cycles = w.indirect ? 4'd6 : 4'd2;
            end
            MODE_INT: begin
                r.pc_out = w.target;
                r.taken  = 1'b1;
                r.cycles = 4'd2;
            end
            MODE_RET: begin
                r.pc_out = {w.pc_in[23:16], w.return_address[15:0]};
                r.sp_out = w.sp_in + 16'd2;
                r.taken  = 1'b1;
                r.cycles = 4'd4;
            end
            MODE_RETF: begin
                r.pc_out = w.return_address;
                r.sp_out = w.sp_in + 16'd3;
                r.taken  = 1'b1;
                r.cycles = 4'd5;
            end
            MODE_CALL: begin
                r.pc_out = near_pc;
                r.cycles = w.indirect ? 4'd6 : 4'd4;
                n_push   = 2;
            end
            MODE_CALLR: begin
                r.pc_out = rel_pc(w.pc_in, w.offset);
                r.cycles = 4'd4;
                n_push   = 2;
            end
            MODE_CALLF: begin
                r.pc_out = w.target;
                r.cycles = w.indirect ? 4'd8 : 4'd5;
                n_push   = 3;
            end
            default: ;   // undefined mode: everything passes through, nothing taken
        endcase
        if (n_push == 0) begin
            predicted_words.push_back(r);
        end else begin
            // one word per stacked byte, low byte first, sp decremented after each
            sp = w.sp_in;
            r.taken       = 1'b1;
            r.write_valid = 1'b1;
            for (int k = 0; k < n_push; k++) begin
                r.write_address = sp;
                r.write_byte    = w.pc_in[8*k +: 8];
                sp              = sp - 16'd1;
                r.sp_out        = sp;
                r.last          = (k == n_push - 1);
                predicted_words.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("t=%0t %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(string what, logic [23:0] got, logic [23:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Fully random instruction, leaning toward defined modes and conditions
    function automatic t_bcfu_in rand_word();
        t_bcfu_in w;
        w.mode = ($urandom_range(9) == 0)
            ? 4'($urandom_range(MODE_UNKNOWN_LAST, MODE_UNKNOWN_FIRST))
            : 4'($urandom_range(MODE_RETF));
        w.cond = ($urandom_range(6) == 0)
            ? 5'($urandom_range(COND_UNKNOWN_LAST, COND_UNKNOWN_FIRST))
            : 5'($urandom_range(COND_LO));
        w.bit_index      = 3'($urandom);
        w.test_byte      = 8'($urandom);
        w.offset         = 8'($urandom);
        w.target         = 24'($urandom);
        w.indirect       = 1'($urandom);
        w.index_y        = 1'($urandom);
        w.return_address = 24'($urandom);
        w.pc_in          = 24'($urandom);
        w.flags_in       = 8'($urandom);
        // stack pointer near either end now and then, to hit wraparound
        case ($urandom_range(7))
            0:       w.sp_in = 16'($urandom_range(2));
            1:       w.sp_in = 16'hFFFF - 16'($urandom_range(2));
            default: w.sp_in = 16'($urandom);
        endcase
        return w;
    endfunction

    function automatic t_bcfu_in base_word(logic [3:0] mode);
        t_bcfu_in w;
        w = rand_word();
        w.mode = mode;
        return w;
    endfunction

    // Driver: present queued instructions, predict each one as it is taken
    always @(posedge i_clk) begin
        t_bcfu_in nxt_word;
        logic     nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_word  = i_in_word;
            if (i_in_valid && o_in_ready) begin
                predict_branch(i_in_word);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_instrs.size() > 0
                && $urandom_range(99) >= sender_idle_pct) begin
                nxt_word  = pending_instrs.pop_front();
                nxt_valid = 1'b1;
            end
            i_in_valid <= nxt_valid;
            i_in_word  <= nxt_word;
        end
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_bcfu_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_words.size() == 0) begin
                report_mismatch("unexpected word, pc_out", o_out_word.pc_out, '0);
            end else begin
                want = predicted_words.pop_front();
                check_field("pc_out", o_out_word.pc_out, want.pc_out);
                check_field("sp_out", 24'(o_out_word.sp_out), 24'(want.sp_out));
                check_field("flags_out", 24'(o_out_word.flags_out), 24'(want.flags_out));
                check_field("taken", 24'(o_out_word.taken), 24'(want.taken));
                check_field("cycles", 24'(o_out_word.cycles), 24'(want.cycles));
                check_field("write_valid", 24'(o_out_word.write_valid),
                            24'(want.write_valid));
                check_field("write_address", 24'(o_out_word.write_address),
                            24'(want.write_address));
                check_field("write_byte", 24'(o_out_word.write_byte),
                            24'(want.write_byte));
                check_field("last", 24'(o_out_word.last), 24'(want.last));
            end
        end
    end

    // Watchdog on traffic
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved in %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_instrs.size() > 0 || i_in_valid || predicted_words.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(int n_items, int idle_pct, int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n_items) pending_instrs.push_back(rand_word());
        drain();
    endtask

    // Stimulus sequence
    initial begin
        t_bcfu_in w;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // relative jumps: wrap above and below, never-true, undefined code, flag tests
        w = base_word(MODE_JRCC); w.cond = COND_T; w.offset = 8'h7F; w.pc_in = 24'hFFFFF0;
        pending_instrs.push_back(w);
        w = base_word(MODE_JRCC); w.cond = COND_T; w.offset = 8'h80; w.pc_in = 24'h000010;
        pending_instrs.push_back(w);
        w = base_word(MODE_JRCC); w.cond = COND_F; w.flags_in = 8'hFF;
        pending_instrs.push_back(w);
        w = base_word(MODE_JRCC); w.cond = COND_UNKNOWN_LAST; w.flags_in = 8'hFF;
        pending_instrs.push_back(w);
        w = base_word(MODE_JRCC); w.cond = COND_EQ; w.flags_in = 8'h02;
        pending_instrs.push_back(w);
        w = base_word(MODE_JRCC); w.cond = COND_LT; w.flags_in = 8'h04;
        pending_instrs.push_back(w);

        // bit test and jump, both senses, hit and miss
        w = base_word(MODE_BTJT); w.bit_index = 3'd7; w.test_byte = 8'h80; w.flags_in = 8'h00;
        pending_instrs.push_back(w);
        w = base_word(MODE_BTJT); w.bit_index = 3'd0; w.test_byte = 8'hFE; w.flags_in = 8'hFF;
        pending_instrs.push_back(w);
        w = base_word(MODE_BTJF); w.bit_index = 3'd0; w.test_byte = 8'h00; w.flags_in = 8'h00;
        pending_instrs.push_back(w);
        w = base_word(MODE_BTJF); w.bit_index = 3'd3; w.test_byte = 8'hFF; w.flags_in = 8'hFF;
        pending_instrs.push_back(w);

        // jumps: near keeps the bank byte, cycle variants
        w = base_word(MODE_JP); w.indirect = 1'b1;
        pending_instrs.push_back(w);
        w = base_word(MODE_JP); w.indirect = 1'b0; w.index_y = 1'b1;
        w.target = 24'hFFFFFF; w.pc_in = 24'hAB0000;
        pending_instrs.push_back(w);
        w = base_word(MODE_JP); w.indirect = 1'b0; w.index_y = 1'b0;
        pending_instrs.push_back(w);
        w = base_word(MODE_JPF); w.indirect = 1'b1; w.target = 24'hFFFFFF;
        pending_instrs.push_back(w);
        w = base_word(MODE_JPF); w.indirect = 1'b0; w.target = 24'h000000;
        pending_instrs.push_back(w);

        // calls: stack wrap through zero, all push counts
        w = base_word(MODE_CALL); w.indirect = 1'b1; w.sp_in = 16'h0000; w.pc_in = 24'hFFFFFF;
        pending_instrs.push_back(w);
        w = base_word(MODE_CALL); w.indirect = 1'b0; w.sp_in = 16'hFFFF;
        pending_instrs.push_back(w);
        w = base_word(MODE_CALLR); w.offset = 8'h80; w.pc_in = 24'h000010; w.sp_in = 16'h0001;
        pending_instrs.push_back(w);
        w = base_word(MODE_CALLF); w.indirect = 1'b1; w.sp_in = 16'h0001; w.pc_in = 24'h123456;
        pending_instrs.push_back(w);
        w = base_word(MODE_CALLF); w.indirect = 1'b0; w.target = 24'h000000;
        pending_instrs.push_back(w);

        // interrupt, returns with stack wrap, undefined modes
        w = base_word(MODE_INT);
        pending_instrs.push_back(w);
        w = base_word(MODE_RET); w.sp_in = 16'hFFFF; w.return_address = 24'hFFFFFF;
        w.pc_in = 24'h120000;
        pending_instrs.push_back(w);
        w = base_word(MODE_RETF); w.sp_in = 16'hFFFE; w.return_address = 24'hFFFFFF;
        pending_instrs.push_back(w);
        w = base_word(MODE_UNKNOWN_LAST);
        pending_instrs.push_back(w);
        w = base_word(MODE_UNKNOWN_FIRST);
        pending_instrs.push_back(w);

        // random traffic under the idling phases
        run_phase(22, 0, 0);
        run_phase(22, 53, 0);
        run_phase(22, 0, 53);
        run_phase(22, 20, 20);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
